>>> rtl/gcuf_pkg.sv
// types and constants shared by the grid union-find design
`default_nettype none
package gcuf_pkg;

  localparam int unsigned DIM_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned PROD_W    = 2 * DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;
  localparam logic [DIM_W-1:0]     DIM_RESET     = 7'd64;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ANS_BINARY  = 2'd0,
    ANS_DECIMAL = 2'd1,
    ANS_NEITHER = 2'd2,
    ANS_RANGE   = 2'd3
  } answer_e;

  typedef struct packed {
    logic             kind;
    logic             cell_bit;
    logic [DIM_W-1:0] first_row;
    logic [DIM_W-1:0] first_col;
    logic [DIM_W-1:0] second_row;
    logic [DIM_W-1:0] second_col;
  } in_item_t;

  typedef struct packed {
    logic [1:0] answer;
  } out_item_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_WALK,
    F_COMP,
    F_DONE
  } find_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_LOAD,
    S_UP_CHK,
    S_LEFT_RD,
    S_LEFT_CHK,
    S_FIND_A,
    S_FIND_B,
    S_LOAD_END,
    S_Q_ADDR,
    S_Q_START,
    S_RESULT
  } ctrl_state_e;

endpackage
`default_nettype wire

>>> rtl/gcuf_stream_if.sv
// valid/ready channel carrying one item
`default_nettype none
interface gcuf_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/grid_component_union_find.sv
// top level: grid loader, query sequencer and cell memory
//
//   channel  dir  payload                                   handshake
//   in_i     in   kind, cell_bit, first/second row and col  valid/ready
//   out_o    out  answer                                    valid/ready
//   cfg      in   cfg_idx_i, cfg_data_i                     cfg_we_i
//
// one item at a time; every parent hop costs one memory read
// load: write the cell, then up to two joins (upper, then left neighbour), each two finds
// query: address computation plus two finds; a bad coordinate goes straight to the result
// after a config write the next load rederives row and column from the position by division,
// unless it restarts a shrunk grid; reset clears control and sets the config to DIM_RESET,
// memories are never cleared; the result waits in an output register; a new item is taken meanwhile
`default_nettype none
module grid_component_union_find #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  gcuf_stream_if.sink                    in_i,
  gcuf_stream_if.source                  out_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [gcuf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [gcuf_pkg::DIM_W-1:0]     cfg_data_i
);
  import gcuf_pkg::*;

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = (AW > 1) ? $clog2(AW) : 1;

  // config registers and the clamped grid size
  logic [DIM_W-1:0]  grid_rows_q, grid_cols_q;
  logic [DIM_W-1:0]  rows, cols;
  logic [PROD_W-1:0] cells;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= DIM_RESET;
      grid_cols_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_ROWS: grid_rows_q <= cfg_data_i;
        REG_GRID_COLS: grid_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_rows_q == '0) begin
      rows = DIM_W'(1);
    end else if (32'(grid_rows_q) > MAX_ROWS) begin
      rows = DIM_W'(MAX_ROWS);
    end else begin
      rows = grid_rows_q;
    end
    if (grid_cols_q == '0) begin
      cols = DIM_W'(1);
    end else if (32'(grid_cols_q) > MAX_COLS) begin
      cols = DIM_W'(MAX_COLS);
    end else begin
      cols = grid_cols_q;
    end
  end

  assign cells = rows * cols;

  // control registers
  ctrl_state_e      state_q, state_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [DIM_W-1:0] row_q, row_d;
  logic [DIM_W-1:0] col_q, col_d;
  logic             dirty_q, dirty_d;
  logic             out_valid_q, out_valid_d;

  // payload registers
  logic [1:0]       out_ans_q, out_ans_d;
  logic [1:0]       ans_q, ans_d;
  logic             bit_q, bit_d;
  logic             qry_q, qry_d;
  logic             left_q, left_d;
  logic [AW-1:0]    nb_q, nb_d;
  logic [AW-1:0]    ra_q, ra_d;
  logic [AW-1:0]    a_q, a_d;
  logic [AW-1:0]    b_q, b_d;
  logic [DIM_W-1:0] r1_q, r1_d, c1_q, c1_d, r2_q, r2_d, c2_q, c2_d;
  logic [DIM_W-1:0] rem_q, rem_d;
  logic [AW-1:0]    quo_q, quo_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  // cell memory
  logic          cell_mem [DEPTH];
  logic          cell_rd_q;
  logic          cell_we;
  logic          cell_re;
  logic [AW-1:0] cell_ra;

  // find unit hookup
  logic          find_start;
  logic [AW-1:0] find_node;
  logic          par_we;
  logic [AW-1:0] par_wa;
  logic [AW-1:0] par_wd;
  logic          find_busy;
  logic          find_done;
  logic [AW-1:0] find_root;

  gcuf_find #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_find (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (find_start),
    .node_i    (find_node),
    .wr_en_i   (par_we),
    .wr_addr_i (par_wa),
    .wr_data_i (par_wd),
    .busy_o    (find_busy),
    .done_o    (find_done),
    .root_o    (find_root)
  );

  // helpers
  logic              bad_coord;
  logic [DIM_W:0]    rem_sh;
  logic              div_ge;
  logic [PROD_W-1:0] prod_a, prod_b;
  logic [DIM_W-1:0]  col_inc;

  assign bad_coord =
      (in_i.data.first_row  == '0) || (in_i.data.first_row  > rows) ||
      (in_i.data.first_col  == '0) || (in_i.data.first_col  > cols) ||
      (in_i.data.second_row == '0) || (in_i.data.second_row > rows) ||
      (in_i.data.second_col == '0) || (in_i.data.second_col > cols);

  // one restoring-division step per cycle to rebuild row and column from the position
  assign rem_sh = {rem_q, pos_q[cnt_q]};
  assign div_ge = rem_sh >= {1'b0, cols};

  assign prod_a  = r1_q * cols;
  assign prod_b  = r2_q * cols;
  assign col_inc = col_q + DIM_W'(1);

  assign in_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      dirty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      row_q       <= row_d;
      col_q       <= col_d;
      dirty_q     <= dirty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ans_q <= out_ans_d;
    ans_q     <= ans_d;
    bit_q     <= bit_d;
    qry_q     <= qry_d;
    left_q    <= left_d;
    nb_q      <= nb_d;
    ra_q      <= ra_d;
    a_q       <= a_d;
    b_q       <= b_d;
    r1_q      <= r1_d;
    c1_q      <= c1_d;
    r2_q      <= r2_d;
    c2_q      <= c2_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    cnt_q     <= cnt_d;
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    row_d       = row_q;
    col_d       = col_q;
    dirty_d     = dirty_q | cfg_we_i;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_ans_d   = out_ans_q;
    ans_d       = ans_q;
    bit_d       = bit_q;
    qry_d       = qry_q;
    left_d      = left_q;
    nb_d        = nb_q;
    ra_d        = ra_q;
    a_d         = a_q;
    b_d         = b_q;
    r1_d        = r1_q;
    c1_d        = c1_q;
    r2_d        = r2_q;
    c2_d        = c2_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    cell_we     = 1'b0;
    cell_re     = 1'b0;
    cell_ra     = pos_q;
    find_start  = 1'b0;
    find_node   = pos_q;
    par_we      = 1'b0;
    par_wa      = pos_q;
    par_wd      = pos_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.data.kind == KIND_LOAD) begin
            bit_d = in_i.data.cell_bit;
            qry_d = 1'b0;
            if (32'(pos_q) >= 32'(cells)) begin
              // grid shrank under the load position: start a fresh grid
              pos_d   = '0;
              row_d   = '0;
              col_d   = '0;
              dirty_d = 1'b0;
              state_d = S_LOAD;
            end else if (dirty_q) begin
              rem_d   = '0;
              quo_d   = '0;
              cnt_d   = CW'(AW - 1);
              state_d = S_DIV;
            end else begin
              state_d = S_LOAD;
            end
          end else begin
            qry_d = 1'b1;
            if (bad_coord) begin
              ans_d   = ANS_RANGE;
              state_d = S_RESULT;
            end else begin
              r1_d    = in_i.data.first_row  - DIM_W'(1);
              c1_d    = in_i.data.first_col  - DIM_W'(1);
              r2_d    = in_i.data.second_row - DIM_W'(1);
              c2_d    = in_i.data.second_col - DIM_W'(1);
              state_d = S_Q_ADDR;
            end
          end
        end
      end
      S_DIV: begin
        rem_d = div_ge ? DIM_W'(rem_sh - {1'b0, cols}) : rem_sh[DIM_W-1:0];
        quo_d = (quo_q << 1) | AW'(div_ge);
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          row_d   = DIM_W'(quo_d);
          col_d   = rem_d;
          dirty_d = 1'b0;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        // new cell is its own root; fetch the upper neighbour meanwhile
        cell_we = 1'b1;
        par_we  = 1'b1;
        cell_re = 1'b1;
        cell_ra = pos_q - AW'(cols);
        state_d = S_UP_CHK;
      end
      S_UP_CHK: begin
        if ((row_q != '0) && (cell_rd_q == bit_q)) begin
          find_start = 1'b1;
          nb_d       = pos_q - AW'(cols);
          left_d     = 1'b0;
          state_d    = S_FIND_A;
        end else begin
          state_d = S_LEFT_RD;
        end
      end
      S_LEFT_RD: begin
        if (col_q != '0) begin
          cell_re = 1'b1;
          cell_ra = pos_q - AW'(1);
          state_d = S_LEFT_CHK;
        end else begin
          state_d = S_LOAD_END;
        end
      end
      S_LEFT_CHK: begin
        if (cell_rd_q == bit_q) begin
          find_start = 1'b1;
          nb_d       = pos_q - AW'(1);
          left_d     = 1'b1;
          state_d    = S_FIND_A;
        end else begin
          state_d = S_LOAD_END;
        end
      end
      S_FIND_A: begin
        if (find_done) begin
          ra_d       = find_root;
          find_start = 1'b1;
          find_node  = nb_q;
          state_d    = S_FIND_B;
        end
      end
      S_FIND_B: begin
        if (find_done) begin
          if (qry_q) begin
            if (ra_q == find_root) begin
              ans_d = cell_rd_q ? ANS_DECIMAL : ANS_BINARY;
            end else begin
              ans_d = ANS_NEITHER;
            end
            state_d = S_RESULT;
          end else begin
            // join: root of the new cell goes under the neighbour's root
            if (ra_q != find_root) begin
              par_we = 1'b1;
              par_wa = ra_q;
              par_wd = find_root;
            end
            state_d = left_q ? S_LOAD_END : S_LEFT_RD;
          end
        end
      end
      S_LOAD_END: begin
        if (32'(pos_q) + 32'd1 >= 32'(cells)) begin
          pos_d = '0;
          row_d = '0;
          col_d = '0;
        end else begin
          pos_d = pos_q + AW'(1);
          if (col_inc == cols) begin
            col_d = '0;
            row_d = row_q + DIM_W'(1);
          end else begin
            col_d = col_inc;
          end
        end
        state_d = S_IDLE;
      end
      S_Q_ADDR: begin
        a_d     = AW'(prod_a + PROD_W'(c1_q));
        b_d     = AW'(prod_b + PROD_W'(c2_q));
        state_d = S_Q_START;
      end
      S_Q_START: begin
        cell_re    = 1'b1;
        cell_ra    = a_q;
        find_start = 1'b1;
        find_node  = a_q;
        nb_d       = b_q;
        state_d    = S_FIND_A;
      end
      S_RESULT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_ans_d   = ans_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[pos_q] <= bit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_re) begin
      cell_rd_q <= cell_mem[cell_ra];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.data.answer = out_ans_q;

  // load position always addresses a real entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) < DEPTH)
    else $error("load position beyond memory");

  // row and column counters stay inside the grid while no config change is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) && !dirty_q |-> (col_q < cols) && (row_q < rows))
    else $error("row or column counter outside grid");

  // the find unit only reports back while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    find_done |-> (state_q == S_FIND_A) || (state_q == S_FIND_B))
    else $error("find result with no one waiting");

  // parent writes from the sequencer never collide with compression
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    par_we |-> !find_busy)
    else $error("parent write while find walks");

  // a range answer comes straight from the accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.data.kind == KIND_QUERY) && bad_coord
    |=> (state_q == S_RESULT) && (ans_q == ANS_RANGE))
    else $error("range check lost");

endmodule
`default_nettype wire

>>> rtl/gcuf_find.sv
// find unit with path compression over the parent memory
`default_nettype none
module gcuf_find #(
  parameter int unsigned AW    = 12,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [AW-1:0] node_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [AW-1:0] wr_data_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [AW-1:0]      root_o
);
  import gcuf_pkg::*;

  logic [AW-1:0] par_mem [DEPTH];
  logic [AW-1:0] rd_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          comp_we;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [AW-1:0] mem_wd;

  find_state_e   state_q, state_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [AW-1:0] node_q, node_d;
  logic [AW-1:0] root_q, root_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    node_q <= node_d;
    root_q <= root_d;
  end

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    node_d  = node_q;
    root_d  = root_q;
    rd_en   = 1'b0;
    rd_addr = cur_q;
    comp_we = 1'b0;
    unique case (state_q)
      F_IDLE, F_DONE: begin
        if (start_i) begin
          rd_en   = 1'b1;
          rd_addr = node_i;
          cur_d   = node_i;
          node_d  = node_i;
          state_d = F_WALK;
        end else begin
          state_d = F_IDLE;
        end
      end
      F_WALK: begin
        if (rd_q == cur_q) begin
          root_d = cur_q;
          if (cur_q == node_q) begin
            state_d = F_DONE;
          end else begin
            // second pass from the start node, pointing each entry at the root
            cur_d   = node_q;
            rd_en   = 1'b1;
            rd_addr = node_q;
            state_d = F_COMP;
          end
        end else begin
          cur_d   = rd_q;
          rd_en   = 1'b1;
          rd_addr = rd_q;
        end
      end
      F_COMP: begin
        comp_we = 1'b1;
        if (rd_q == root_q) begin
          state_d = F_DONE;
        end else begin
          cur_d   = rd_q;
          rd_en   = 1'b1;
          rd_addr = rd_q;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign mem_we = comp_we | wr_en_i;
  assign mem_wa = comp_we ? cur_q : wr_addr_i;
  assign mem_wd = comp_we ? root_q : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      par_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= par_mem[rd_addr];
    end
  end

  assign busy_o = (state_q == F_WALK) || (state_q == F_COMP);
  assign done_o = (state_q == F_DONE);
  assign root_o = root_q;

endmodule
`default_nettype wire

>>> sim/testbench.sv
// testbench for the grid union-find labeler: predictor, stimulus and result checks
`timescale 1ns / 100ps
module testbench;
  import gcuf_pkg::*;

  localparam int unsigned GRID_MAX   = 64;
  localparam int unsigned CELL_COUNT = GRID_MAX * GRID_MAX;
  localparam int unsigned IDLE_LIMIT = 40000;
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned SETTLE     = 60;
  localparam int unsigned RANDOM_ITEMS = 700;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DIM_W-1:0] cfg_data_i = '0;

  gcuf_stream_if #(.T(in_item_t))  in_if ();
  gcuf_stream_if #(.T(out_item_t)) out_if ();

  grid_component_union_find u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the labeler state
  logic [DIM_W-1:0] rows_reg = DIM_RESET;
  logic [DIM_W-1:0] cols_reg = DIM_RESET;
  bit   cell_val [CELL_COUNT];
  int   parent_of [CELL_COUNT];
  bit   written [CELL_COUNT];   // cells that have been loaded at least once
  int   next_cell = 0;

  answer_e answer_q[$];         // answers still owed by the block
  int  fail_count = 0;
  int  items_sent = 0;
  int  burst_left = 0;
  bit  last_bit = 1'b0;

  // receiver behavior: 0 always ready, 1 random stalls, 2 fixed duty pattern
  int  recv_mode = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  recv_phase = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.data  = '0;
    out_if.ready = 1'b0;
  end

  // clamp a raw register value into the usable grid size
  function automatic int clamp_dim(logic [DIM_W-1:0] raw);
    if (raw < 1) return 1;
    if (raw > GRID_MAX) return GRID_MAX;
    return int'(raw);
  endfunction

  // root lookup with path compression, as the block does it
  function automatic int find_root(int node);
    int root;
    int cur;
    int up;
    root = node;
    while (parent_of[root] != root) root = parent_of[root];
    cur = node;
    while (cur != root) begin
      up = parent_of[cur];
      parent_of[cur] = root;
      cur = up;
    end
    return root;
  endfunction

  function automatic void join_cells(int a, int b);
    int ra;
    int rb;
    ra = find_root(a);
    rb = find_root(b);
    if (ra != rb) parent_of[ra] = rb;
  endfunction

  // advance the shadow state by one accepted item and record any owed answer
  function automatic void apply_item(in_item_t it);
    int rows;
    int cols;
    int cells;
    int p;
    int a;
    int b;
    rows = clamp_dim(rows_reg);
    cols = clamp_dim(cols_reg);
    cells = rows * cols;
    if (it.kind == KIND_LOAD) begin
      // a shrunk grid pulls the load position back to the start
      if (next_cell >= cells) next_cell = 0;
      p = next_cell;
      cell_val[p] = it.cell_bit;
      parent_of[p] = p;
      written[p] = 1'b1;
      if (p / cols > 0 && cell_val[p - cols] == it.cell_bit) join_cells(p, p - cols);
      if (p % cols > 0 && cell_val[p - 1] == it.cell_bit) join_cells(p, p - 1);
      next_cell = p + 1;
      if (next_cell >= cells) next_cell = 0;
    end else begin
      if (it.first_row < 1 || it.first_row > rows || it.first_col < 1 ||
          it.first_col > cols || it.second_row < 1 || it.second_row > rows ||
          it.second_col < 1 || it.second_col > cols) begin
        answer_q.push_back(ANS_RANGE);
      end else begin
        a = (int'(it.first_row) - 1) * cols + int'(it.first_col) - 1;
        b = (int'(it.second_row) - 1) * cols + int'(it.second_col) - 1;
        if (find_root(a) == find_root(b))
          answer_q.push_back(cell_val[a] ? ANS_DECIMAL : ANS_BINARY);
        else
          answer_q.push_back(ANS_NEITHER);
      end
    end
  endfunction

  function automatic in_item_t load_item(bit value);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});   // coordinates are don't-care on loads
    it.kind = KIND_LOAD;
    it.cell_bit = value;
    return it;
  endfunction

  // query by coordinates; an in-range query on a never-loaded cell is turned bad
  function automatic in_item_t query_item(int r1, int c1, int r2, int c2);
    in_item_t it;
    int rows;
    int cols;
    rows = clamp_dim(rows_reg);
    cols = clamp_dim(cols_reg);
    it.kind = KIND_QUERY;
    it.cell_bit = $urandom_range(0, 1);
    it.first_row = r1;
    it.first_col = c1;
    it.second_row = r2;
    it.second_col = c2;
    if (r1 >= 1 && r1 <= rows && c1 >= 1 && c1 <= cols &&
        r2 >= 1 && r2 <= rows && c2 >= 1 && c2 <= cols) begin
      if (!written[(r1 - 1) * cols + c1 - 1] || !written[(r2 - 1) * cols + c2 - 1])
        it.first_row = '0;
    end
    return it;
  endfunction

  function automatic in_item_t random_query(bit wild);
    int rows;
    int cols;
    rows = clamp_dim(rows_reg);
    cols = clamp_dim(cols_reg);
    if (wild)
      return query_item($urandom_range(0, 127), $urandom_range(0, 127),
                        $urandom_range(0, 127), $urandom_range(0, 127));
    return query_item($urandom_range(1, rows), $urandom_range(1, cols),
                      $urandom_range(1, rows), $urandom_range(1, cols));
  endfunction

  // drive one item, in bursts with random gaps; returns right after acceptance
  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    apply_item(it);
    items_sent++;
    burst_left--;
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
  endtask

  // wait until every owed answer is back and the block has settled
  task automatic drain();
    stop_sending();
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // registers are only written once the block is idle
  task automatic set_grid(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols);
    // a trailing query makes sure the last load has finished
    send_item(query_item(1, 1, 1, 1));
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_GRID_ROWS;
    cfg_data_i <= rows;
    @(posedge clk_i);
    rows_reg = rows;
    cfg_idx_i  <= REG_GRID_COLS;
    cfg_data_i <= cols;
    @(posedge clk_i);
    cols_reg = cols;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // fill n cells with runs of equal bits so that regions actually form
  task automatic load_cells(int n, int query_every);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) last_bit = ~last_bit;
      send_item(load_item(last_bit));
      if (query_every > 0 && $urandom_range(1, query_every) == 1)
        send_item(random_query($urandom_range(0, 7) == 0));
    end
  endtask

  // small grid with known regions, every answer kind and the wraparound
  task automatic test_directed();
    bit pattern [12] = '{1, 1, 0, 0,
                         0, 1, 0, 1,
                         0, 1, 1, 1};
    int i;
    set_grid(3, 4);
    for (i = 0; i < 12; i++) send_item(load_item(pattern[i]));
    send_item(query_item(1, 1, 3, 3));     // ones joined through the middle column
    send_item(query_item(1, 3, 2, 3));     // zeros
    send_item(query_item(1, 3, 3, 1));     // separate zero regions
    send_item(query_item(3, 4, 2, 4));     // ones joined from below
    send_item(query_item(0, 1, 1, 1));     // zero row
    send_item(query_item(1, 5, 1, 1));     // column past the grid
    send_item(query_item(1, 1, 4, 1));     // row past the grid
    send_item(query_item(1, 1, 127, 127)); // all coordinate bits set
    // the next load wraps back to the top-left corner of the grid
    send_item(load_item(1'b0));
    send_item(query_item(1, 1, 1, 2));
    send_item(query_item(1, 1, 1, 1));
  endtask

  // register values past either end clamp to the usable range
  task automatic test_clamped_dims();
    set_grid(0, 127);                      // one row of 64
    load_cells(64, 4);
    send_item(query_item(1, 1, 1, 64));
    send_item(query_item(1, 65, 1, 1));
    set_grid(127, 0);                      // 64 rows of one
    load_cells(64, 4);
    send_item(query_item(1, 1, 64, 1));
    send_item(query_item(1, 2, 1, 1));
  endtask

  // grid shrinks while the load position sits beyond its end
  task automatic test_shrink();
    set_grid(6, 6);
    load_cells(20, 3);
    set_grid(2, 3);
    load_cells(6, 2);
    send_item(query_item(1, 1, 2, 3));
    send_item(query_item(3, 1, 1, 1));
  endtask

  // receiver stalls for a long stretch while queries keep coming
  task automatic test_backpressure();
    int i;
    set_grid(4, 4);
    load_cells(16, 0);
    hold_req = 1'b1;
    for (i = 0; i < 30; i++) send_item(random_query($urandom_range(0, 3) == 0));
  endtask

  // random grids, mostly small, with the full row or column count now and then
  task automatic test_random_grids();
    int rows;
    int cols;
    int target;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      recv_mode = $urandom_range(0, 2);
      case ($urandom_range(0, 9))
        0: begin
          rows = 64;
          cols = $urandom_range(1, 3);
        end
        1: begin
          rows = $urandom_range(1, 3);
          cols = 64;
        end
        default: begin
          rows = $urandom_range(1, 10);
          cols = $urandom_range(1, 10);
        end
      endcase
      set_grid(rows, cols);
      // a full grid plus a partial second pass over it
      load_cells(rows * cols + $urandom_range(0, rows * cols), 3);
    end
  endtask

  // receiver ready as set by recv_mode, with an occasional long hold
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_LEN;
    end
    recv_phase = (recv_phase + 1) % 7;
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (recv_mode)
        1: out_if.ready <= ($urandom_range(0, 2) != 0);
        2: out_if.ready <= (recv_phase < 3);
        default: out_if.ready <= 1'b1;
      endcase
    end
  end

  // answer checker
  always @(posedge clk_i) begin
    answer_e want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (answer_q.size() == 0) begin
        $error("unexpected answer %0d", out_if.data.answer);
        fail_count++;
      end else begin
        want = answer_q.pop_front();
        if (out_if.data.answer !== want) begin
          $error("answer mismatch: expected %0d, actual %0d", want, out_if.data.answer);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving either way
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    recv_mode = 1;
    test_directed();
    recv_mode = 2;
    test_clamped_dims();
    recv_mode = 0;
    test_shrink();
    test_backpressure();
    test_random_grids();
    drain();
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
